// ===== rtl/matrix3_inverse_unit_macros.svh =====
// ---------------------------------------------------------------------------
// matrix3_inverse_unit_macros.svh
// Assertion macros for the 3x3 matrix inverse unit. The macros expect clk and
// rst_n in scope. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define M3I_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3i assertion failed");
// Check cons in the cycle after ante.
`define M3I_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3i assertion failed");
`else
`define M3I_ASSERT_IMP(label, ante, cons)
`define M3I_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/m3i_pkg.sv =====
// ---------------------------------------------------------------------------
// m3i_pkg
// Payload types and cofactor index tables for the 3x3 matrix inverse unit.
// ---------------------------------------------------------------------------
package m3i_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] entry_t;

    typedef struct packed {
        entry_t a00;
        entry_t a01;
        entry_t a02;
        entry_t a10;
        entry_t a11;
        entry_t a12;
        entry_t a20;
        entry_t a21;
        entry_t a22;
    } item_t;

    typedef struct packed {
        entry_t b00;
        entry_t b01;
        entry_t b02;
        entry_t b10;
        entry_t b11;
        entry_t b12;
        entry_t b20;
        entry_t b21;
        entry_t b22;
        logic   singular;
        logic   saturated;
    } result_t;

    // Adjugate entry k = a[p]*a[q] - a[s]*a[t], entries flattened row major.
    localparam int unsigned COF_TERM [9][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    // Determinant expands along row 0: a0j times adjugate entry DET_COF[j].
    localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

// ===== rtl/matrix3_inverse_unit.sv =====
// Throughput: one matrix per cycle unless the skid register is full; the divider has one
//   quotient bit per stage in each of nine lanes.
// A full output register plus skid register hold results while result_ready is low.
// Reset clears all valid bits, including the output and skid valid flags; data needs none.
// ---------------------------------------------------------------------------
// matrix3_inverse_unit
// Inverse of a signed fixed-point 3x3 matrix via adjugate over determinant,
// truncated toward zero and saturated, with singular and saturated flags.
// ---------------------------------------------------------------------------
`include "matrix3_inverse_unit_macros.svh"

module matrix3_inverse_unit import m3i_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    output logic    item_ready,
    output result_t result,
    output logic    result_valid,
    input  logic    result_ready
);

    localparam int W      = DATA_W;
    localparam int PW     = 2 * W;       // entry product
    localparam int CW     = 2 * W + 1;   // cofactor
    localparam int TW     = 2 * W + 1;   // determinant partial product
    localparam int DW     = 3 * W + 3;   // determinant
    localparam int QW     = W + 1;       // quotient bits incl. overflow bit
    localparam int STAGES = 6 + QW + 1;
    localparam int LAST   = STAGES - 1;

    // Pipeline advance: the whole pipe moves unless the skid register is occupied.
    logic adv;
    logic emit;
    logic vld_reg [STAGES];

    entry_t a [9];

    assign a[0] = item.a00;
    assign a[1] = item.a01;
    assign a[2] = item.a02;
    assign a[3] = item.a10;
    assign a[4] = item.a11;
    assign a[5] = item.a12;
    assign a[6] = item.a20;
    assign a[7] = item.a21;
    assign a[8] = item.a22;

    // Stage 1: the eighteen entry products.
    logic signed [PW-1:0] s1_pa_reg  [9];
    logic signed [PW-1:0] s1_pb_reg  [9];
    entry_t               s1_row_reg [3];
    // Stage 2: cofactors.
    logic signed [CW-1:0] s2_cof_reg [9];
    entry_t               s2_row_reg [3];
    // Stage 3: determinant partial products, cofactor split at bit W.
    logic signed [TW-1:0] s3_plo_reg [3];
    logic signed [TW-1:0] s3_phi_reg [3];
    logic signed [CW-1:0] s3_cof_reg [9];
    // Stage 4: recombined row terms.
    logic signed [DW-1:0] s4_term_reg [3];
    logic signed [CW-1:0] s4_cof_reg  [9];
    // Stage 5: determinant.
    logic signed [DW-1:0] s5_det_reg;
    logic signed [CW-1:0] s5_cof_reg [9];
    // Stage 6: magnitudes and signs for the dividers.
    logic [DW-1:0]        s6_dmag_reg;
    logic                 s6_zero_reg;
    logic [CW-1:0]        s6_nmag_reg [9];
    logic                 s6_neg_reg  [9];

    logic [QW-1:0]        lane_q   [9];
    logic                 lane_neg [9];
    logic                 zd_reg   [QW];

    result_t fin_next;
    result_t fin_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    assign adv        = !skid_valid_reg;
    assign item_ready = adv;
    assign emit       = adv && vld_reg[LAST];

    // Advance valid bits alongside data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Arithmetic front end: products, cofactors, determinant, magnitudes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                s1_pa_reg[k] <= a[COF_TERM[k][0]] * a[COF_TERM[k][1]];
                s1_pb_reg[k] <= a[COF_TERM[k][2]] * a[COF_TERM[k][3]];
                s2_cof_reg[k] <= CW'(s1_pa_reg[k]) - CW'(s1_pb_reg[k]);
                s3_cof_reg[k] <= s2_cof_reg[k];
                s4_cof_reg[k] <= s3_cof_reg[k];
                s5_cof_reg[k] <= s4_cof_reg[k];
                s6_nmag_reg[k] <= s5_cof_reg[k][CW-1] ? CW'(-s5_cof_reg[k])
                                                      : CW'(s5_cof_reg[k]);
                s6_neg_reg[k]  <= s5_cof_reg[k][CW-1] ^ s5_det_reg[DW-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                s1_row_reg[j] <= a[j];
                s2_row_reg[j] <= s1_row_reg[j];
                s3_plo_reg[j] <= s2_row_reg[j]
                                 * $signed({1'b0, s2_cof_reg[DET_COF[j]][W-1:0]});
                s3_phi_reg[j] <= s2_row_reg[j]
                                 * $signed(s2_cof_reg[DET_COF[j]][CW-1:W]);
                s4_term_reg[j] <= (DW'(s3_phi_reg[j]) <<< W) + DW'(s3_plo_reg[j]);
            end
            s5_det_reg  <= s4_term_reg[0] + s4_term_reg[1] + s4_term_reg[2];
            s6_dmag_reg <= s5_det_reg[DW-1] ? DW'(-s5_det_reg) : DW'(s5_det_reg);
            s6_zero_reg <= (s5_det_reg == '0);
            zd_reg[0]   <= s6_zero_reg;
            for (int k = 1; k < QW; k++)
            begin
                zd_reg[k] <= zd_reg[k-1];
            end
            fin_reg <= fin_next;
        end
    end

    // Nine division lanes share the determinant magnitude.
    for (genvar k = 0; k < 9; k++) begin : g_lane
        m3i_div_lane #(
            .NUM_W (CW),
            .DEN_W (DW),
            .Q_W   (QW),
            .SHIFT (2 * FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (adv),
            .num     (s6_nmag_reg[k]),
            .den     (s6_dmag_reg),
            .neg_in  (s6_neg_reg[k]),
            .quo     (lane_q[k]),
            .neg_out (lane_neg[k])
        );
    end

    // Saturate, apply sign, and drop everything for a singular matrix.
    always_comb
    begin
        logic [W-1:0] val   [9];
        logic [W-1:0] bound [9];
        logic [8:0]   clip;
        entry_t       b     [9];

        clip = '0;
        for (int k = 0; k < 9; k++)
        begin
            val[k]   = lane_q[k][W-1:0];
            bound[k] = lane_neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            if (lane_q[k][W] || (val[k] > bound[k]))
            begin
                val[k]  = bound[k];
                clip[k] = 1'b1;
            end
            b[k] = lane_neg[k] ? entry_t'(-val[k]) : entry_t'(val[k]);
            if (zd_reg[QW-1])
            begin
                b[k] = '0;
            end
        end
        fin_next.b00       = b[0];
        fin_next.b01       = b[1];
        fin_next.b02       = b[2];
        fin_next.b10       = b[3];
        fin_next.b11       = b[4];
        fin_next.b12       = b[5];
        fin_next.b20       = b[6];
        fin_next.b21       = b[7];
        fin_next.b22       = b[8];
        fin_next.singular  = zd_reg[QW-1];
        fin_next.saturated = !zd_reg[QW-1] && (clip != '0);
    end

    // Output register with skid: the skid catches the one transfer that
    // arrives after result_ready drops, since item_ready is registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end
        else if (emit)
        begin
            skid_reg <= fin_reg;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    `M3I_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `M3I_ASSERT_NXT(a_skid_drains, skid_valid_reg && result_ready, !skid_valid_reg && out_valid_reg)
    `M3I_ASSERT_IMP(a_singular_clean, out_valid_reg && out_reg.singular,
        !out_reg.saturated && out_reg.b00 == '0 && out_reg.b11 == '0 && out_reg.b22 == '0)
    `M3I_ASSERT_NXT(a_entry_tracked, item_valid && item_ready, vld_reg[0])

endmodule

// ===== rtl/m3i_div_lane.sv =====
// ---------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider, one quotient bit per stage, numerator
// pre-shifted left by SHIFT. Quotient MSB flags a quotient of 2^(Q_W-1) or more.
// ---------------------------------------------------------------------------
module m3i_div_lane #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 99,
    parameter int Q_W   = 33,
    parameter int SHIFT = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg_in,
    output logic [Q_W-1:0]   quo,
    output logic             neg_out
);

    localparam int RW = DEN_W + Q_W;

    logic [RW-1:0]    rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic             neg_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int BIT = Q_W - 1 - s;
        logic [RW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic             neg_i;
        logic [RW-1:0]    den_sh;
        logic [RW:0]      diff;

        if (s == 0) begin : g_first
            assign rem_in = RW'(num) << SHIFT;
            assign den_in = den;
            assign q_in   = '0;
            assign neg_i  = neg_in;
        end
        else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign neg_i  = neg_reg[s-1];
        end

        assign den_sh = RW'(den_in) << BIT;
        assign diff   = {1'b0, rem_in} - {1'b0, den_sh};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s]   <= {q_in[Q_W-2:0], ~diff[RW]};
                neg_reg[s] <= neg_i;
            end
        end

        if (s < Q_W - 1) begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= diff[RW] ? rem_in : diff[RW-1:0];
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo     = q_reg[Q_W-1];
    assign neg_out = neg_reg[Q_W-1];

endmodule
